>>> rtl/lut_linear_interpolator_macros.svh
`ifndef LUT_LINEAR_INTERPOLATOR_MACROS_SVH
`define LUT_LINEAR_INTERPOLATOR_MACROS_SVH

// Assertion helpers. Each expects clk and arst_n in scope.

`define LLI_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

`define LLI_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define LLI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/lli_pkg.sv
`default_nettype none

package lli_pkg;

	localparam int XW = 20;
	localparam int YW = 8;
	localparam int DyW = YW + 1;
	localparam int OutW = 24;
	localparam int TableDepth = 30;
	localparam int IdxW = $clog2(TableDepth);
	localparam int QueueDepth = 2;

	localparam int DefPointCount = 30;
	localparam int DefFractionBits = 16;

	localparam logic signed [OutW-1:0] TempMax = 24'sh7F_FFFF;
	localparam logic signed [OutW-1:0] TempMin = 24'sh80_0000;

	typedef struct packed {
		logic [XW-1:0] x;
		logic signed [YW-1:0] y;
	} cal_point_t;

	// Calibration points, resistance ascending.
	localparam cal_point_t CalTable [TableDepth] = '{
		'{20'd387, 8'sd120}, '{20'd443, 8'sd115}, '{20'd508, 8'sd110},
		'{20'd584, 8'sd105}, '{20'd674, 8'sd100}, '{20'd782, 8'sd95},
		'{20'd909, 8'sd90}, '{20'd1062, 8'sd85}, '{20'd1246, 8'sd80},
		'{20'd1473, 8'sd75}, '{20'd1738, 8'sd70}, '{20'd2066, 8'sd65},
		'{20'd2468, 8'sd60}, '{20'd2963, 8'sd55}, '{20'd3588, 8'sd50},
		'{20'd4341, 8'sd45}, '{20'd5298, 8'sd40}, '{20'd6504, 8'sd35},
		'{20'd8034, 8'sd30}, '{20'd10000, 8'sd25}, '{20'd12499, 8'sd20},
		'{20'd15751, 8'sd15}, '{20'd19993, 8'sd10}, '{20'd25570, 8'sd5},
		'{20'd32960, 8'sd0}, '{20'd42834, -8'sd5}, '{20'd56142, -8'sd10},
		'{20'd74238, -8'sd15}, '{20'd99077, -8'sd20}, '{20'd133500, -8'sd25}
	};

	// One classified item handed from the segment search to the divider.
	typedef struct packed {
		logic hit;
		logic signed [YW-1:0] y0;
		logic signed [DyW-1:0] dy;
		logic [XW-1:0] off;
		logic [XW-1:0] span;
	} seg_item_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_SEARCH,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIVIDE,
		B_MULTIPLY,
		B_FINISH
	} back_state_t;

endpackage

`default_nettype wire

>>> rtl/lli_queue.sv
`default_nettype none
`include "lut_linear_interpolator_macros.svh"

module lli_queue
	import lli_pkg::*;
#(
	parameter int Width = 8,
	parameter int Depth = QueueDepth
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr_valid,
	output logic wr_ready,
	input wire logic [Width-1:0] wr_data,
	output logic rd_valid,
	input wire logic rd_ready,
	output logic [Width-1:0] rd_data
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

	logic [Width-1:0] slot_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic push;
	logic pop;

	assign wr_ready = (count_q != FullCnt);
	assign rd_valid = (count_q != '0);
	assign rd_data = slot_q[rd_ptr_q];
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	`LLI_ASSERT_ALWAYS(a_count_bound, count_q <= FullCnt, "queue count beyond depth")
	`LLI_ASSERT_NEXT(a_count_grows, push && !pop, count_q == $past(count_q) + 1'b1, "queue count did not grow on push")

endmodule

`default_nettype wire

>>> rtl/lli_front.sv
`default_nettype none
`include "lut_linear_interpolator_macros.svh"

module lli_front
	import lli_pkg::*;
#(
	parameter int POINT_COUNT = DefPointCount
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [XW-1:0] resistance,
	output logic push_valid,
	input wire logic push_ready,
	output seg_item_t push_item
);

	localparam int ActivePoints = (POINT_COUNT < TableDepth) ? POINT_COUNT : TableDepth;
	localparam logic [IdxW-1:0] LastSeg = IdxW'(ActivePoints - 2);

	front_state_t state_q, state_d;
	logic [XW-1:0] x_q;
	logic [IdxW-1:0] idx_q;
	logic [IdxW-1:0] idx_next;
	seg_item_t item_q;
	seg_item_t item_d;
	cal_point_t p0;
	cal_point_t p1;
	logic seg_hit;
	logic search_done;

	// The segment under test is idx_q .. idx_q + 1; one segment per cycle.
	assign idx_next = idx_q + 1'b1;
	assign p0 = CalTable[idx_q];
	assign p1 = CalTable[idx_next];
	assign seg_hit = (p0.x <= x_q) && (x_q <= p1.x);
	assign search_done = seg_hit || (idx_q == LastSeg);
	assign push_item = item_q;

	always_comb begin
		item_d = '0;
		item_d.hit = seg_hit;
		if (seg_hit) begin
			item_d.y0 = p0.y;
			item_d.dy = DyW'(p1.y) - DyW'(p0.y);
			item_d.off = x_q - p0.x;
			item_d.span = p1.x - p0.x;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		push_valid = 1'b0;
		unique case (state_q)
			F_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = F_SEARCH;
				end
			end
			F_SEARCH: begin
				if (search_done) begin
					state_d = F_PUSH;
				end
			end
			F_PUSH: begin
				push_valid = 1'b1;
				if (push_ready) begin
					state_d = F_IDLE;
				end
			end
			default: begin
				state_d = F_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && in_valid) begin
			x_q <= resistance;
			idx_q <= '0;
		end else if (state_q == F_SEARCH) begin
			if (search_done) begin
				item_q <= item_d;
			end else begin
				idx_q <= idx_next;
			end
		end
	end

	`LLI_ASSERT_IMPLY(a_idx_in_table, state_q == F_SEARCH, idx_q <= LastSeg, "segment index past last segment")

endmodule

`default_nettype wire

>>> rtl/lli_back.sv
`default_nettype none
`include "lut_linear_interpolator_macros.svh"

module lli_back
	import lli_pkg::*;
#(
	parameter int FRACTION_BITS = DefFractionBits
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic pop_valid,
	output logic pop_ready,
	input wire seg_item_t pop_item,
	output logic out_valid,
	input wire logic out_ready,
	output logic signed [OutW-1:0] temperature_q16,
	output logic in_range
);

	localparam int F = FRACTION_BITS;
	localparam int QW = F + 1;
	localparam int ProdW = DyW + QW + 1;
	localparam int SumW = F + 12;
	localparam int StepW = $clog2(F);
	localparam logic [StepW-1:0] LastStep = StepW'(F - 1);
	localparam logic signed [SumW-1:0] SatMax = SumW'(TempMax);
	localparam logic signed [SumW-1:0] SatMin = SumW'(TempMin);

	back_state_t state_q, state_d;
	seg_item_t item_q;
	logic [XW:0] rem_q;
	logic [QW-1:0] quo_q;
	logic [StepW-1:0] step_q;
	logic signed [ProdW-1:0] prod_q;
	logic out_valid_q;
	logic signed [OutW-1:0] temp_q;
	logic in_range_q;

	logic out_load;
	logic [XW:0] rem2;
	logic [XW:0] span_ext;
	logic trial;
	logic signed [QW:0] quo_signed;
	logic signed [SumW-1:0] base;
	logic signed [SumW-1:0] sum;
	logic signed [OutW-1:0] sat;

	// Restoring division: the remainder stays below the span, so doubling
	// it fits in one more bit than the span.
	assign span_ext = {1'b0, item_q.span};
	assign rem2 = {rem_q[XW-1:0], 1'b0};
	assign trial = (item_q.span != '0) && (rem2 >= span_ext);
	assign quo_signed = signed'({1'b0, quo_q});

	assign base = SumW'(item_q.y0) <<< F;
	assign sum = base + SumW'(prod_q);

	always_comb begin
		if (sum > SatMax) begin
			sat = TempMax;
		end else if (sum < SatMin) begin
			sat = TempMin;
		end else begin
			sat = sum[OutW-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign temperature_q16 = temp_q;
	assign in_range = in_range_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		pop_ready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid) begin
					state_d = pop_item.hit ? B_DIVIDE : B_FINISH;
				end
			end
			B_DIVIDE: begin
				if (step_q == LastStep) begin
					state_d = B_MULTIPLY;
				end
			end
			B_MULTIPLY: begin
				state_d = B_FINISH;
			end
			B_FINISH: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && pop_valid) begin
			item_q <= pop_item;
			step_q <= '0;
			// A resistance on the upper end of a segment gives a whole quotient of one.
			if (pop_item.span != '0 && pop_item.off == pop_item.span) begin
				quo_q <= QW'(1);
				rem_q <= '0;
			end else begin
				quo_q <= '0;
				rem_q <= {1'b0, pop_item.off};
			end
		end else if (state_q == B_DIVIDE) begin
			rem_q <= trial ? rem2 - span_ext : rem2;
			quo_q <= {quo_q[QW-2:0], trial};
			step_q <= step_q + 1'b1;
		end else if (state_q == B_MULTIPLY) begin
			prod_q <= item_q.dy * quo_signed;
		end
		if (out_load) begin
			temp_q <= item_q.hit ? sat : '0;
			in_range_q <= item_q.hit;
		end
	end

	`LLI_ASSERT_IMPLY(a_rem_below_span, state_q == B_DIVIDE && item_q.span != '0, rem_q < span_ext, "divider remainder not below span")
	`LLI_ASSERT_IMPLY(a_miss_is_zero, out_valid_q && !in_range_q, temp_q == '0, "out-of-range result not zero")

endmodule

`default_nettype wire

>>> rtl/lut_linear_interpolator.sv
// Resistance to temperature converter by piecewise-linear table interpolation.
//
// Input channel s_*: one item per measured resistance (ohms, 20 bits unsigned).
// Output channel m_*: one item per input, in order: the temperature in signed
// fixed point with FRACTION_BITS fractional bits, and in_range on tuser. A
// resistance outside the table gives temperature 0 with in_range low.
//
// The search tests one segment per cycle. A hit in segment k (0 to 28) then
// passes the queue, the one-bit-per-cycle divider, the multiply and the output
// register before m_tvalid rises. An item outside the table skips the divider
// and the multiply. The search and the divider run side by side through a
// two-item queue, so the search can take a new item while the divider still
// works on an earlier one.
//
// Reset empties the queue and drops m_tvalid. When the receiver stalls, the
// result is held on m_tdata/m_tuser, one more item waits finished in the
// divider, two sit in the queue and the search holds one; s_tready then stays
// low until m_tready frees a place.
`default_nettype none

module lut_linear_interpolator
	import lli_pkg::*;
#(
	parameter int POINT_COUNT = DefPointCount,
	parameter int FRACTION_BITS = DefFractionBits
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [23:0] s_tdata,   // [19:0] resistance
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [23:0] m_tdata,       // [23:0] temperature_q16
	output logic [0:0] m_tuser         // [0] in_range
);

	logic push_valid;
	logic push_ready;
	seg_item_t push_item;
	logic pop_valid;
	logic pop_ready;
	seg_item_t pop_item;
	logic signed [OutW-1:0] temperature_q16;
	logic in_range;

	lli_front #(
		.POINT_COUNT(POINT_COUNT)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.resistance(s_tdata[XW-1:0]),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item(push_item)
	);

	lli_queue #(
		.Width($bits(seg_item_t)),
		.Depth(QueueDepth)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_valid(push_valid),
		.wr_ready(push_ready),
		.wr_data(push_item),
		.rd_valid(pop_valid),
		.rd_ready(pop_ready),
		.rd_data(pop_item)
	);

	lli_back #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_item(pop_item),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.temperature_q16(temperature_q16),
		.in_range(in_range)
	);

	assign m_tdata = temperature_q16;
	assign m_tuser = in_range;

endmodule

`default_nettype wire

>>> dv/lut_linear_interpolator_test.sv
module lut_linear_interpolator_test;
	timeunit 1ns;
	timeprecision 1ps;

	import lli_pkg::*;

	localparam int PointCount = 30;
	localparam int FracBits = 16;
	localparam longint SatHigh = 64'sd8388607;
	localparam longint SatLow = -64'sd8388608;
	localparam int unsigned ResMax = 20'hFFFFF;

	// Calibration points as the converter's constant CalTable holds them.
	localparam longint CalOhms [30] = '{
		387, 443, 508, 584, 674, 782, 909, 1062, 1246, 1473,
		1738, 2066, 2468, 2963, 3588, 4341, 5298, 6504, 8034, 10000,
		12499, 15751, 19993, 25570, 32960, 42834, 56142, 74238, 99077, 133500
	};
	localparam longint CalDeg [30] = '{
		120, 115, 110, 105, 100, 95, 90, 85, 80, 75,
		70, 65, 60, 55, 50, 45, 40, 35, 30, 25,
		20, 15, 10, 5, 0, -5, -10, -15, -20, -25
	};

	typedef struct {
		logic signed [OutW-1:0] temp;
		logic in_range;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [23:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [0:0] m_tuser;

	logic [XW-1:0] resistances_pending [$];
	reading_t readings_due [$];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int errors = 0;

	lut_linear_interpolator i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always #2 clk = ~clk;

	// Searches the segments from the lowest point up; the first enclosing one wins.
	function automatic reading_t convert_resistance(logic [XW-1:0] ohms);
		reading_t r;
		longint xv;
		longint span;
		longint frac;
		longint t;
		bit hit;
		xv = longint'(ohms);
		hit = 0;
		t = 0;
		for (int i = 0; i + 1 < PointCount && !hit; i++) begin
			if (CalOhms[i] <= xv && xv <= CalOhms[i+1]) begin
				span = CalOhms[i+1] - CalOhms[i];
				frac = 0;
				if (span > 0)
					frac = ((xv - CalOhms[i]) <<< FracBits) / span;
				t = (CalDeg[i] <<< FracBits) + (CalDeg[i+1] - CalDeg[i]) * frac;
				hit = 1;
			end
		end
		if (t > SatHigh)
			t = SatHigh;
		if (t < SatLow)
			t = SatLow;
		r.temp = t[OutW-1:0];
		r.in_range = hit;
		return r;
	endfunction

	function automatic logic [XW-1:0] random_resistance();
		int k;
		longint v;
		k = $urandom_range(29);
		case ($urandom_range(9))
			0: v = $urandom_range(386);
			1: v = $urandom_range(ResMax, 133501);
			2: v = CalOhms[k];
			3: v = CalOhms[k] + ($urandom_range(1) ? 1 : -1);
			default: begin
				k = $urandom_range(28);
				v = CalOhms[k] + $urandom_range(int'(CalOhms[k+1] - CalOhms[k]));
			end
		endcase
		return v[XW-1:0];
	endfunction

	// Driver: a new item is presented once the previous one has been taken.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				readings_due.push_back(convert_resistance(s_tdata[XW-1:0]));
			if (!s_tvalid || s_tready) begin
				if (resistances_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tdata <= {4'b0, resistances_pending.pop_front()};
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: each result item is checked against the oldest prediction.
	always @(posedge clk) begin
		reading_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (readings_due.size() == 0) begin
					$error("result with nothing expected: temperature_q16 %0d in_range %0b",
						$signed(m_tdata), m_tuser[0]);
					errors++;
				end else begin
					want = readings_due.pop_front();
					if (m_tdata !== want.temp) begin
						$error("temperature_q16: expected %0d, got %0d",
							want.temp, $signed(m_tdata));
						errors++;
					end
					if (m_tuser[0] !== want.in_range) begin
						$error("in_range: expected %0b, got %0b", want.in_range, m_tuser[0]);
						errors++;
					end
				end
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		#4ms;
		$display("FAIL lut_linear_interpolator");
		$finish;
	end

	initial begin
		logic [XW-1:0] corner_values [$];
		int idle_plan [4][2];
		int randoms;
		idle_plan = '{'{0, 0}, '{66, 0}, '{0, 66}, '{37, 37}};
		// Ends of the field, table edges, shared breakpoints and bit patterns.
		corner_values = '{20'd0, 20'd386, 20'd387, 20'd388, 20'd415, 20'd443, 20'd444,
			20'd32960, 20'd42834, 20'd20000, 20'd100000, 20'd133499, 20'd133500,
			20'd133501, 20'h80000, 20'hAAAAA, 20'h55555, 20'hFFFFF};

		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct = idle_plan[phase][0];
			recv_stall_pct = idle_plan[phase][1];
			randoms = 260;
			if (phase == 0) begin
				foreach (corner_values[i])
					resistances_pending.push_back(corner_values[i]);
				randoms = 250;
			end
			for (int n = 0; n < randoms; n++)
				resistances_pending.push_back(random_resistance());
			while (resistances_pending.size() != 0 || s_tvalid)
				@(posedge clk);
		end

		while (readings_due.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("PASS lut_linear_interpolator");
		else
			$display("FAIL lut_linear_interpolator");
		$finish;
	end

endmodule
